FILE: sv/assert_macros.svh
// Assertion macros shared by the voice ADC conditioner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define VAC_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define VAC_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle implication failed");

`endif

FILE: sv/vac_pkg.sv
// Package with widths, register indexes, reset values and types of the conditioner.
`timescale 1ns / 1ps
`default_nettype none

package vac_pkg;

    // Sample and DC tracker geometry.
    localparam int SAMPLE_BITS  = 12;
    localparam int OFFSET_SHIFT = 11;
    localparam int ACC_W        = SAMPLE_BITS + OFFSET_SHIFT;
    localparam int X_W          = SAMPLE_BITS + 1;
    localparam int D_W          = X_W + 1;

    // Filter formats: state carries FRAC_BITS fraction bits, alpha is Q0.16.
    localparam int FRAC_BITS = 8;
    localparam int Y_W       = 32;
    localparam int YMAG_W    = Y_W - 1;
    localparam int T_W       = Y_W + 1;
    localparam int COEF_W    = 16;
    localparam int GAIN_W    = 4;
    localparam int LIMIT_W   = 15;
    localparam int OUT_W     = 16;
    localparam int RAW_W     = 16;

    // Shared multiplier geometry.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_HPF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    // Reset values.
    localparam logic [COEF_W-1:0]  HPF_RESET   = 16'd58629;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 4'd6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd15500;
    localparam logic [SAMPLE_BITS-1:0] OFFSET_RESET_LEVEL = SAMPLE_BITS'(1551);
    localparam logic [ACC_W-1:0] ACC_RESET = {OFFSET_RESET_LEVEL, {OFFSET_SHIFT{1'b0}}};

    // Rounding constant and saturation level of the filter output.
    localparam logic [MUL_P_W:0] ROUND_HALF = (MUL_P_W + 1)'(1) << (COEF_W - 1);
    localparam logic [T_W-1:0]   Y_MAX      = {2'b00, {YMAG_W{1'b1}}};

    // Live configuration.
    typedef struct packed {
        logic [COEF_W-1:0]  alpha;
        logic [GAIN_W-1:0]  gain;
        logic [LIMIT_W-1:0] limit;
    } vac_cfg_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } vac_mul_req_t;

endpackage

`default_nettype wire

FILE: sv/vac_if.sv
// Stream interfaces for raw ADC words in and conditioned samples out.
`timescale 1ns / 1ps
`default_nettype none

interface vac_in_if;
    logic                         valid;
    logic                         ready;
    logic [vac_pkg::RAW_W-1:0]    raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink (input valid, input raw_sample, output ready);
endinterface

interface vac_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [vac_pkg::OUT_W-1:0] conditioned_sample;

    modport source (output valid, output conditioned_sample, input ready);
    modport sink (input valid, input conditioned_sample, output ready);
endinterface

`default_nettype wire

FILE: sv/vac_cfg_regs.sv
// Configuration register file: alpha, gain and clamp limit.
`timescale 1ns / 1ps
`default_nettype none

module vac_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [vac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vac_pkg::CFG_DATA_W-1:0]   cfg_data,
    output vac_pkg::vac_cfg_t                     cfg
);

    vac_pkg::vac_cfg_t cfg_reg;
    vac_pkg::vac_cfg_t cfg_next;

    // Decode the write; unused indexes leave everything as it is.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                vac_pkg::REG_HPF:   cfg_next.alpha = cfg_data[vac_pkg::COEF_W-1:0];
                vac_pkg::REG_GAIN:  cfg_next.gain  = cfg_data[vac_pkg::GAIN_W-1:0];
                vac_pkg::REG_LIMIT: cfg_next.limit = cfg_data[vac_pkg::LIMIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha <= vac_pkg::HPF_RESET;
            cfg_reg.gain  <= vac_pkg::GAIN_RESET;
            cfg_reg.limit <= vac_pkg::LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/vac_mul_unit.sv
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module vac_mul_unit (
    input  wire logic                           clk,
    input  wire vac_pkg::vac_mul_req_t          req,
    output logic [vac_pkg::MUL_P_W-1:0]         prod
);

    logic [vac_pkg::MUL_P_W-1:0] prod_reg;
    logic [vac_pkg::MUL_P_W-1:0] prod_next;

    // The product register holds until the sequencer issues the next request.
    always_comb
    begin
        prod_next = prod_reg;
        if (req.en)
        begin
            prod_next = vac_pkg::MUL_P_W'(req.a) * vac_pkg::MUL_P_W'(req.b);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: sv/voice_adc_conditioner_core.sv
// Top level of the voice ADC conditioner: DC removal, high-pass, gain and clamp.
// Usage:
//   sample_in carries one raw ADC word per beat; only its low 12 bits are used.
//   sample_out carries one signed conditioned sample per input beat, in order.
//   cfg_we/cfg_index/cfg_data write alpha (0), gain (1) and limit (2) while idle;
//   other indexes are ignored.
// Timing:
//   A beat is taken when the sequencer is idle, and the sequencer goes idle
//   again only after the result is in the output register. Its steps are one
//   each for the DC update, the offset subtract, the filter sum, two passes
//   through the shared multiplier with a rounding step between them, and the
//   clamp.
// Stalls:
//   The result sits in an output register, so the next beat is taken and worked
//   on while it waits. If it is still not taken when the next result is ready,
//   the sequencer holds in its clamp step until the output register frees up.
// Reset:
//   rst_n clears the filter state, loads the DC tracker with 1551 << 11 and the
//   registers with their defaults; no result is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module voice_adc_conditioner_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    vac_in_if.sink                                sample_in,
    vac_out_if.source                             sample_out,
    input  wire logic                             cfg_we,
    input  wire logic [vac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vac_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Sequencer steps.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_DIFF  = 3'd2;
    localparam logic [2:0] ST_TSUM  = 3'd3;
    localparam logic [2:0] ST_MUL1  = 3'd4;
    localparam logic [2:0] ST_RND   = 3'd5;
    localparam logic [2:0] ST_MUL2  = 3'd6;
    localparam logic [2:0] ST_CLAMP = 3'd7;

    vac_pkg::vac_cfg_t      cfg;
    vac_pkg::vac_mul_req_t  mul_req;
    logic [vac_pkg::MUL_P_W-1:0] prod;

    logic [2:0] state_reg, state_next;

    // Filter and tracker state.
    logic [vac_pkg::ACC_W-1:0]            acc_reg, acc_next;
    logic signed [vac_pkg::X_W-1:0]       x_prev_reg, x_prev_next;
    logic signed [vac_pkg::Y_W-1:0]       y_prev_reg, y_prev_next;

    // Per-item working registers.
    logic [vac_pkg::SAMPLE_BITS-1:0]      sample_reg, sample_next;
    logic signed [vac_pkg::X_W-1:0]       x_reg, x_next;
    logic [vac_pkg::MUL_A_W-1:0]          t_mag_reg, t_mag_next;
    logic                                 neg_reg, neg_next;
    logic [vac_pkg::YMAG_W-1:0]           y_mag_reg, y_mag_next;

    // Output register.
    logic                                 out_valid_reg, out_valid_next;
    logic signed [vac_pkg::OUT_W-1:0]     out_data_reg, out_data_next;

    // Step-local values.
    logic                                 in_accept;
    logic                                 out_free;
    logic [vac_pkg::SAMPLE_BITS-1:0]      offset;
    logic signed [vac_pkg::D_W-1:0]       d;
    logic signed [vac_pkg::T_W-1:0]       d_ext;
    logic signed [vac_pkg::T_W-1:0]       t;
    logic [vac_pkg::T_W-1:0]              t_abs;
    logic [vac_pkg::MUL_P_W:0]            rounded;
    logic [vac_pkg::T_W-1:0]              y_full;
    logic [vac_pkg::YMAG_W-1:0]           y_sat;
    logic [vac_pkg::MUL_P_W-1:0]          g_mag;
    logic [vac_pkg::LIMIT_W-1:0]          g_clamped;
    logic signed [vac_pkg::OUT_W-1:0]     g_pos;
    logic [vac_pkg::OUT_W-1:0]            out_mag;

    vac_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vac_mul_unit u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign sample_in.ready = (state_reg == ST_IDLE);
    assign in_accept       = sample_in.valid && sample_in.ready;
    assign out_free        = !out_valid_reg || sample_out.ready;

    // Combinational pieces used by the individual steps.
    always_comb
    begin
        offset = acc_reg[vac_pkg::ACC_W-1:vac_pkg::OFFSET_SHIFT];

        d      = vac_pkg::D_W'(x_reg) - vac_pkg::D_W'(x_prev_reg);
        d_ext  = vac_pkg::T_W'(d);
        t      = vac_pkg::T_W'(y_prev_reg) + (d_ext <<< vac_pkg::FRAC_BITS);
        t_abs  = t[vac_pkg::T_W-1] ? (vac_pkg::T_W'(0) - t) : t;

        rounded = (vac_pkg::MUL_P_W + 1)'(prod) + vac_pkg::ROUND_HALF;
        y_full  = rounded[vac_pkg::COEF_W +: vac_pkg::T_W];
        y_sat   = (y_full > vac_pkg::Y_MAX) ? vac_pkg::Y_MAX[vac_pkg::YMAG_W-1:0]
                                            : y_full[vac_pkg::YMAG_W-1:0];

        g_mag     = prod >> vac_pkg::FRAC_BITS;
        g_clamped = (g_mag > vac_pkg::MUL_P_W'(cfg.limit)) ? cfg.limit
                                                           : g_mag[vac_pkg::LIMIT_W-1:0];
        g_pos     = vac_pkg::OUT_W'(g_clamped);

        out_mag = out_data_reg[vac_pkg::OUT_W-1] ? (vac_pkg::OUT_W'(0) - out_data_reg)
                                                 : out_data_reg;
    end

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        x_prev_next    = x_prev_reg;
        y_prev_next    = y_prev_reg;
        sample_next    = sample_reg;
        x_next         = x_reg;
        t_mag_next     = t_mag_reg;
        neg_next       = neg_reg;
        y_mag_next     = y_mag_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_req.en     = 1'b0;
        mul_req.a      = t_mag_reg;
        mul_req.b      = cfg.alpha;

        if (sample_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = sample_in.raw_sample[vac_pkg::SAMPLE_BITS-1:0];
                    state_next  = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // Leaky DC tracker.
                acc_next   = acc_reg - (acc_reg >> vac_pkg::OFFSET_SHIFT)
                             + vac_pkg::ACC_W'(sample_reg);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                x_next     = vac_pkg::X_W'(sample_reg) - vac_pkg::X_W'(offset);
                state_next = ST_TSUM;
            end
            ST_TSUM:
            begin
                // Filter sum split into sign and magnitude for the multiplier.
                neg_next    = t[vac_pkg::T_W-1];
                t_mag_next  = t_abs[vac_pkg::MUL_A_W-1:0];
                x_prev_next = x_reg;
                state_next  = ST_MUL1;
            end
            ST_MUL1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = t_mag_reg;
                mul_req.b  = cfg.alpha;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                // Round half away from zero on the magnitude, then saturate.
                y_mag_next  = y_sat;
                y_prev_next = neg_reg ? (vac_pkg::Y_W'(0) - vac_pkg::Y_W'(y_sat))
                                      : vac_pkg::Y_W'(y_sat);
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = vac_pkg::MUL_A_W'(y_mag_reg);
                mul_req.b  = vac_pkg::MUL_B_W'(cfg.gain);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // Truncated magnitude is clamped, then the sign goes back on.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = neg_reg ? (vac_pkg::OUT_W'(0) - g_pos) : g_pos;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= vac_pkg::ACC_RESET;
            x_prev_reg    <= '0;
            y_prev_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            x_prev_reg    <= x_prev_next;
            y_prev_reg    <= y_prev_next;
        end
    end

    // Working registers and output payload.
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        x_reg        <= x_next;
        t_mag_reg    <= t_mag_next;
        neg_reg      <= neg_next;
        y_mag_reg    <= y_mag_next;
        out_data_reg <= out_data_next;
    end

    assign sample_out.valid              = out_valid_reg;
    assign sample_out.conditioned_sample = out_data_reg;

    // An accepted beat always starts the DC update step next.
    `VAC_ASSERT_NXT(a_accept_starts, in_accept, state_reg == ST_ACC)
    // A finished clamp step with a free output register delivers and goes idle.
    `VAC_ASSERT_NXT(a_clamp_delivers, (state_reg == ST_CLAMP) && out_free,
                    (state_reg == ST_IDLE) && out_valid_reg)
    // A pending result never exceeds the configured clamp magnitude.
    `VAC_ASSERT_IMP(a_out_in_limit, out_valid_reg,
                    out_mag <= vac_pkg::OUT_W'(cfg.limit))

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the voice ADC conditioner: random traffic, register sweeps, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import vac_pkg::*;

    localparam int CHUNK_WORDS    = 210;
    localparam int RANDOM_CHUNKS  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_FIRST  = 450;
    localparam int HOLD_AT_SECOND = 1200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 20;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vac_in_if  in_bus ();
    vac_out_if out_bus ();

    voice_adc_conditioner_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (in_bus),
        .sample_out (out_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Stimulus and scoreboard storage.
    logic [RAW_W-1:0]        pending_words[$];
    logic signed [OUT_W-1:0] expected_samples[$];

    // Shadow copy of the conditioner state and registers.
    longint unsigned    dc_acc;
    longint             x_prev;
    longint             y_prev;
    logic [COEF_W-1:0]  alpha_q;
    logic [GAIN_W-1:0]  gain_q;
    logic [LIMIT_W-1:0] limit_q;

    int  words_sent;
    int  samples_checked;
    int  mismatch_count;
    int  cfg_writes;
    int  settings_applied;
    int  in_gap;
    int  out_gap;
    int  hold_left;
    int  stall_cycles;
    logic idle_on;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Conditions one ADC word and advances the shadow state.
    function automatic logic signed [OUT_W-1:0] condition_sample(input logic [RAW_W-1:0] raw);
        longint unsigned smp;
        longint unsigned mag;
        longint          x;
        longint          t;
        longint          y;
        longint          g;
        longint          lim;
        logic            neg;
        smp = longint'(raw[SAMPLE_BITS-1:0]);
        dc_acc = dc_acc - (dc_acc >> OFFSET_SHIFT) + smp;
        x = longint'(smp) - longint'(dc_acc >> OFFSET_SHIFT);

        // High-pass step with rounding half away from zero and symmetric saturation.
        t = y_prev + (x - x_prev) * 256;
        neg = (t < 0);
        mag = neg ? -t : t;
        mag = mag * alpha_q;
        mag = (mag + (64'd1 << (COEF_W - 1))) >> COEF_W;
        if (mag > 64'(Y_MAX))
            mag = 64'(Y_MAX);
        y = neg ? -longint'(mag) : longint'(mag);
        x_prev = x;
        y_prev = y;

        // Gain with truncation toward zero, then clamp to the limit.
        neg = (y < 0);
        mag = neg ? -y : y;
        mag = (mag * gain_q) >> FRAC_BITS;
        g = neg ? -longint'(mag) : longint'(mag);
        lim = longint'(limit_q);
        if (g > lim)
            g = lim;
        else if (g < -lim)
            g = -lim;
        return g[OUT_W-1:0];
    endfunction

    // Random ADC word: mostly full range, some rails and some near the resting level.
    function automatic logic [RAW_W-1:0] random_word();
        logic [RAW_W-1:0] w;
        int               pick;
        w = RAW_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            w[SAMPLE_BITS-1:0] = '0;
        else if (pick == 1)
            w[SAMPLE_BITS-1:0] = '1;
        else if (pick < 5)
            w[SAMPLE_BITS-1:0] = SAMPLE_BITS'(1551 + int'($urandom_range(0, 64)) - 32);
        return w;
    endfunction

    // Waits until the sender has nothing left and every result has come back.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_words.size() != 0 || in_bus.valid || expected_samples.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_writes++;
        case (idx)
            REG_HPF:   alpha_q = data[COEF_W-1:0];
            REG_GAIN:  gain_q  = data[GAIN_W-1:0];
            REG_LIMIT: limit_q = data[LIMIT_W-1:0];
            default:   ;
        endcase
    endtask

    // Drains the block, then loads all three registers, with junk in the unused upper bits of gain and limit.
    task automatic apply_setting(input logic [COEF_W-1:0] alpha, input logic [GAIN_W-1:0] gain,
                                 input logic [LIMIT_W-1:0] limit, input logic poke_unused);
        logic [CFG_DATA_W-1:0] junk;
        wait_drained();
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_HPF, alpha);
        write_reg(REG_GAIN, {junk[CFG_DATA_W-1:GAIN_W], gain});
        write_reg(REG_LIMIT, {junk[CFG_DATA_W-1], limit});
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Input driver: offers queued words with random gaps between beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bus.valid      <= 1'b0;
            in_bus.raw_sample <= '0;
        end
        else
        begin
            if (in_bus.valid && in_bus.ready)
            begin
                expected_samples.push_back(condition_sample(in_bus.raw_sample));
                words_sent++;
            end
            if (!in_bus.valid || in_bus.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_bus.valid <= 1'b0;
                end
                else if (pending_words.size() != 0 && idle_on && $urandom_range(0, 7) == 0)
                begin
                    in_gap = $urandom_range(1, 14) - 1;
                    in_bus.valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    in_bus.valid      <= 1'b1;
                    in_bus.raw_sample <= pending_words.pop_front();
                end
                else
                begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each beat against the oldest prediction and paces ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected output beat %0d with nothing predicted",
                                 out_bus.conditioned_sample);
                end
                else if (out_bus.conditioned_sample !== expected_samples[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch on sample %0d: expected %0d, got %0d",
                                 samples_checked, expected_samples[0],
                                 out_bus.conditioned_sample);
                    void'(expected_samples.pop_front());
                end
                else
                begin
                    void'(expected_samples.pop_front());
                end
                samples_checked++;
                if (samples_checked == HOLD_AT_FIRST || samples_checked == HOLD_AT_SECOND)
                    hold_left = LONG_HOLD;
            end

            // Long hold-offs fill the block; short bursts move gaps across every step.
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_bus.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_gap = $urandom_range(1, 14) - 1;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any input beat or any predicted output beat.
    always @(posedge clk)
    begin
        if (!rst_n || (in_bus.valid && in_bus.ready)
            || (out_bus.valid && out_bus.ready && expected_samples.size() != 0))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", stall_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Sequence of phases: directed words, register corners, then random chunks.
    initial
    begin
        logic [COEF_W-1:0]  alpha;
        logic [GAIN_W-1:0]  gain;
        logic [LIMIT_W-1:0] limit;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_bus.valid     = 1'b0;
        in_bus.raw_sample = '0;
        out_bus.ready    = 1'b0;
        idle_on          = 1'b1;
        words_sent       = 0;
        samples_checked  = 0;
        mismatch_count   = 0;
        cfg_writes       = 0;
        settings_applied = 0;
        in_gap           = 0;
        out_gap          = 0;
        hold_left        = 0;
        stall_cycles     = 0;
        dc_acc           = longint'(ACC_RESET);
        x_prev           = 0;
        y_prev           = 0;
        alpha_q          = HPF_RESET;
        gain_q           = GAIN_RESET;
        limit_q          = LIMIT_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default registers: rails, upper bits that must be ignored, full-scale swings.
        pending_words = '{16'h0000, 16'h0FFF, 16'hFFFF, 16'hF000, 16'h0800, 16'h07FF,
                          16'hA5A5, 16'h5A5A, 16'h0001, 16'hFFFE, 16'h0FFF, 16'h0000,
                          16'h0FFF, 16'h0000, 16'h060F, 16'h060F};

        // Largest alpha, gain and limit so that the output clamps on big swings.
        apply_setting('1, '1, '1, 1'b0);
        @(negedge clk);
        pending_words = '{16'h0FFF, 16'hFFFF, 16'h0FFF, 16'h0000, 16'hF000, 16'h0000};

        // A zero limit forces zero output; the unused index must change nothing.
        apply_setting(HPF_RESET, '1, '0, 1'b1);
        @(negedge clk);
        pending_words = '{16'h0FFF, 16'h0000, 16'h0FFF};

        // Zero alpha and zero gain.
        apply_setting('0, '0, LIMIT_RESET, 1'b0);
        @(negedge clk);
        pending_words = '{16'h0FFF, 16'h0000};

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            alpha = COEF_W'($urandom);
            gain  = GAIN_W'($urandom);
            limit = LIMIT_W'($urandom);
            case (chunk)
                1:
                begin
                    alpha = '1;
                    gain  = '1;
                    limit = '1;
                end
                2:
                begin
                    limit = LIMIT_W'($urandom_range(0, 200));
                end
                3:
                begin
                    alpha = '0;
                end
                4:
                begin
                    alpha = HPF_RESET;
                    gain  = GAIN_RESET;
                    limit = LIMIT_RESET;
                end
                6:
                begin
                    gain  = 4'd1;
                    limit = '1;
                end
                default: ;
            endcase
            apply_setting(alpha, gain, limit, chunk == 4);
            if (chunk == RANDOM_CHUNKS - 1)
                idle_on = 1'b0;
            @(negedge clk);
            repeat (CHUNK_WORDS) pending_words.push_back(random_word());
        end

        // Let the last results drain, then give the block a few quiet cycles.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_samples.size() != 0)
            mismatch_count++;

        $display("Sent %0d ADC words under %0d register settings (%0d writes), with stalls",
                 words_sent, settings_applied, cfg_writes);
        $display("on both sides and two long output hold-offs; checked %0d samples, %0d bad.",
                 samples_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
